@@ src/snp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package snp_pkg;

	localparam int MANT_W = 64;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// Lower-case letters; a code ORed with 8'h20 matches both cases.
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_G = 8'h67;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_K = 8'h6B;
	localparam logic [7:0] CH_L = 8'h6C;
	localparam logic [7:0] CH_M = 8'h6D;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_P = 8'h70;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	localparam logic signed [4:0] DL_NONE = 5'sd0;
	localparam logic signed [4:0] DL_T    = 5'sd12;
	localparam logic signed [4:0] DL_G    = 5'sd9;
	localparam logic signed [4:0] DL_MEG  = 5'sd6;
	localparam logic signed [4:0] DL_K    = 5'sd3;
	localparam logic signed [4:0] DL_FRAC = -5'sd1;
	localparam logic signed [4:0] DL_M    = -5'sd3;
	localparam logic signed [4:0] DL_U    = -5'sd6;
	localparam logic signed [4:0] DL_MIL  = -5'sd7;
	localparam logic signed [4:0] DL_N    = -5'sd9;
	localparam logic signed [4:0] DL_P    = -5'sd12;
	localparam logic signed [4:0] DL_F    = -5'sd15;

	localparam logic signed [11:0] EXP_MAX = 12'sd1023;
	localparam logic signed [11:0] EXP_MIN = -12'sd1023;
	localparam logic [13:0] EXP_DIG_MAX = 14'd1023;

	typedef enum logic [1:0] {
		ST_NUM = 2'd0,
		ST_NAN = 2'd1,
		ST_EOL = 2'd2
	} status_t;

	typedef enum logic [14:0] {
		PH_IDLE  = 15'h0001,
		PH_PLUS  = 15'h0002,
		PH_MINUS = 15'h0004,
		PH_INT   = 15'h0008,
		PH_DOT   = 15'h0010,
		PH_FRAC  = 15'h0020,
		PH_E     = 15'h0040,
		PH_ESP   = 15'h0080,
		PH_ESM   = 15'h0100,
		PH_EXP   = 15'h0200,
		PH_M     = 15'h0400,
		PH_ME    = 15'h0800,
		PH_MI    = 15'h1000,
		PH_DONE  = 15'h2000,
		PH_NAN   = 15'h4000
	} phase_t;

	typedef struct packed {
		status_t            status;
		logic               negative;
		logic [MANT_W-1:0]  mantissa;
		logic signed [10:0] dec_exponent;
		logic               overflowed;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               sat;
		logic signed [10:0] val;
	} fexp_t;

	typedef struct packed {
		phase_t            ph;
		logic signed [4:0] delta;
	} scale_t;

	function automatic fexp_t frac_add(input logic signed [10:0] a,
		input logic signed [4:0] d);
		logic signed [11:0] s;
		fexp_t r;
		s = 12'(a) + 12'(d);
		r.sat = 1'b0;
		r.val = s[10:0];
		if (s > EXP_MAX) begin
			r.sat = 1'b1;
			r.val = EXP_MAX[10:0];
		end else if (s < EXP_MIN) begin
			r.sat = 1'b1;
			r.val = EXP_MIN[10:0];
		end
		return r;
	endfunction

	function automatic fexp_t exp_total(input logic signed [10:0] fr, input logic neg,
		input logic [9:0] ed);
		logic [11:0] e12;
		logic signed [11:0] s;
		fexp_t r;
		e12 = {2'b00, ed};
		s = 12'(fr) + $signed(neg ? (12'd0 - e12) : e12);
		r.sat = 1'b0;
		r.val = s[10:0];
		if (s > EXP_MAX) begin
			r.sat = 1'b1;
			r.val = EXP_MAX[10:0];
		end else if (s < EXP_MIN) begin
			r.sat = 1'b1;
			r.val = EXP_MIN[10:0];
		end
		return r;
	endfunction

	function automatic scale_t scale_of(input logic [7:0] lc);
		scale_t r;
		r.ph = PH_DONE;
		r.delta = DL_NONE;
		case (lc)
			CH_T: r.delta = DL_T;
			CH_G: r.delta = DL_G;
			CH_K: r.delta = DL_K;
			CH_U: r.delta = DL_U;
			CH_N: r.delta = DL_N;
			CH_P: r.delta = DL_P;
			CH_F: r.delta = DL_F;
			CH_M: r.ph = PH_M;
			default: r.delta = DL_NONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/scaled_number_token_parser_top.sv @@
// Scaled number token parser.
// Input channel (req_valid / req_stall) carries one character per beat with
// line_end marking the last character of a line. Output channel
// (rsp_valid / rsp_stall) carries one result per beat: a parsed number
// (sign, 64-bit mantissa, decimal exponent, overflow flag), a not-a-number
// token, or an end-of-line marker. last is set on the final result that a
// character causes; a character causes zero, one or two results.
// A character is registered at acceptance and parsed from that register once
// the result queue has room; its results are written into the queue, from
// which the output reads them. One character is accepted per cycle while
// req_stall is low; sustained output is one result per cycle while rsp_stall
// is low, set by the single read port of the four-entry result queue.
// Reset clears the token state and empties the queue; no result is pending.
// When the receiver stalls, results wait in the queue, and req_stall rises
// once the queue cannot take the two results the next character may cause.
`timescale 1ns / 1ps
`default_nettype none

module scaled_number_token_parser_top #(
	parameter int MANT_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic [7:0]    char_code,
	input  wire logic          line_end,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic [1:0]         status,
	output logic               negative,
	output logic [63:0]        mantissa,
	output logic signed [10:0] dec_exponent,
	output logic               overflowed,
	output logic               last
);
	import snp_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        le_s1;
	logic        room, fire, accept;
	res_t        res0, res1, rd_data;
	logic [1:0]  nres;

	assign fire      = valid_s1 && room;
	assign req_stall = valid_s1 && !room;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			le_s1 <= line_end;
		end
	end

	snp_parse #(
		.MANT_BITS (MANT_BITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.line_end  (le_s1),
		.res0      (res0),
		.res1      (res1),
		.nres      (nres)
	);

	snp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (fire ? nres : 2'd0),
		.wr0      (res0),
		.wr1      (res1),
		.room     (room),
		.rd_valid (rsp_valid),
		.rd_stall (rsp_stall),
		.rd_data  (rd_data)
	);

	assign status       = rd_data.status;
	assign negative     = rd_data.negative;
	assign mantissa     = rd_data.mantissa;
	assign dec_exponent = rd_data.dec_exponent;
	assign overflowed   = rd_data.overflowed;
	assign last         = rd_data.last;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(char_s1) && $stable(le_s1))
		else $error("stalled character lost from the input register");

endmodule

`default_nettype wire

@@ src/snp_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module snp_parse #(
	parameter int MANT_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   char_code,
	input  wire logic         line_end,
	output snp_pkg::res_t     res0,
	output snp_pkg::res_t     res1,
	output logic [1:0]        nres
);
	import snp_pkg::*;

	localparam logic [MANT_BITS-1:0] MANT_MAX = {MANT_BITS{1'b1}};

	phase_t                 phase_q;
	logic                   sign_q;
	logic [MANT_BITS-1:0]   acc_q;
	logic signed [10:0]     frac_q;
	logic                   eneg_q;
	logic [9:0]             ed_q;
	logic                   sat_q;

	logic [7:0]             lc;
	logic                   sep, dig, is_e;
	scale_t                 sc;
	phase_t                 ph_f;
	logic                   sign_f, eneg_f, push_d, push_e, do_mil;
	logic signed [4:0]      delta;

	logic [MANT_BITS+3:0]   p10;
	logic [MANT_BITS+7:0]   p254;
	logic [13:0]            e10;
	fexp_t                  fr_f;
	logic [MANT_BITS-1:0]   acc_f;
	logic [9:0]             ed_f;
	logic                   sat_f;

	phase_t                 k_ph;
	logic                   k_sign, k_eneg, k_sat;
	logic [MANT_BITS-1:0]   k_acc;
	logic signed [10:0]     k_frac;
	logic [9:0]             k_ed;
	fexp_t                  fa, fe;
	res_t                   fin, eol;
	logic                   fin_emit;

	assign lc   = char_code | 8'h20;
	assign sep  = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_EQ)
		|| (char_code == CH_LPAR) || (char_code == CH_RPAR) || (char_code == CH_COMMA);
	assign dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_e = (lc == CH_E) || (lc == CH_D);
	assign sc   = scale_of(lc);

	always_comb begin
		ph_f   = phase_q;
		sign_f = sign_q;
		eneg_f = eneg_q;
		push_d = 1'b0;
		push_e = 1'b0;
		do_mil = 1'b0;
		delta  = DL_NONE;
		case (phase_q)
			PH_IDLE, PH_PLUS, PH_MINUS: begin
				if (phase_q == PH_IDLE && char_code == CH_PLUS) begin
					ph_f = PH_PLUS;
				end else if (phase_q != PH_MINUS && char_code == CH_MINUS) begin
					sign_f = 1'b1;
					ph_f = PH_MINUS;
				end else if (dig) begin
					push_d = 1'b1;
					ph_f = PH_INT;
				end else if (char_code == CH_DOT) begin
					ph_f = PH_DOT;
				end else begin
					ph_f = PH_NAN;
				end
			end
			PH_INT: begin
				if (dig) begin
					push_d = 1'b1;
				end else if (char_code == CH_COLON) begin
					ph_f = PH_NAN;
				end else if (char_code == CH_DOT) begin
					ph_f = PH_DOT;
				end else if (is_e) begin
					ph_f = PH_E;
				end else begin
					ph_f = sc.ph;
					delta = sc.delta;
				end
			end
			PH_DOT, PH_FRAC: begin
				if (dig) begin
					push_d = 1'b1;
					delta = DL_FRAC;
					ph_f = PH_FRAC;
				end else if (is_e) begin
					ph_f = PH_E;
				end else begin
					ph_f = sc.ph;
					delta = sc.delta;
				end
			end
			PH_E, PH_ESP, PH_ESM, PH_EXP: begin
				if (phase_q == PH_E && char_code == CH_PLUS) begin
					ph_f = PH_ESP;
				end else if ((phase_q == PH_E || phase_q == PH_ESP)
					&& char_code == CH_MINUS) begin
					eneg_f = 1'b1;
					ph_f = PH_ESM;
				end else if (dig) begin
					push_e = 1'b1;
					ph_f = PH_EXP;
				end else begin
					ph_f = sc.ph;
					delta = sc.delta;
				end
			end
			PH_M: begin
				if (lc == CH_E) begin
					ph_f = PH_ME;
				end else if (lc == CH_I) begin
					ph_f = PH_MI;
				end else begin
					delta = DL_M;
					ph_f = PH_DONE;
				end
			end
			PH_ME: begin
				delta = (lc == CH_G) ? DL_MEG : DL_M;
				ph_f = PH_DONE;
			end
			PH_MI: begin
				do_mil = (lc == CH_L);
				delta = (lc == CH_L) ? DL_MIL : DL_M;
				ph_f = PH_DONE;
			end
			default: begin
				ph_f = phase_q;
			end
		endcase
	end

	assign p10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ (MANT_BITS+4)'(char_code[3:0]);
	assign p254 = {acc_q, 8'h00} - {7'b0000000, acc_q, 1'b0};
	assign e10  = {1'b0, ed_q, 3'b000} + {3'b000, ed_q, 1'b0} + 14'(char_code[3:0]);
	assign fr_f = frac_add(frac_q, delta);

	always_comb begin
		acc_f = acc_q;
		ed_f  = ed_q;
		sat_f = sat_q | fr_f.sat;
		if (push_d) begin
			if (|p10[MANT_BITS+3:MANT_BITS]) begin
				acc_f = MANT_MAX;
				sat_f = 1'b1;
			end else begin
				acc_f = p10[MANT_BITS-1:0];
			end
		end else if (do_mil) begin
			if (|p254[MANT_BITS+7:MANT_BITS]) begin
				acc_f = MANT_MAX;
				sat_f = 1'b1;
			end else begin
				acc_f = p254[MANT_BITS-1:0];
			end
		end
		if (push_e) begin
			if (e10 > EXP_DIG_MAX) begin
				ed_f = EXP_DIG_MAX[9:0];
				sat_f = 1'b1;
			end else begin
				ed_f = e10[9:0];
			end
		end
	end

	// A separator skips the character itself and closes the token as it stands.
	assign k_ph   = sep ? phase_q : ph_f;
	assign k_sign = sep ? sign_q : sign_f;
	assign k_eneg = sep ? eneg_q : eneg_f;
	assign k_sat  = sep ? sat_q : sat_f;
	assign k_acc  = sep ? acc_q : acc_f;
	assign k_frac = sep ? frac_q : fr_f.val;
	assign k_ed   = sep ? ed_q : ed_f;

	assign fa = (k_ph == PH_M || k_ph == PH_ME || k_ph == PH_MI)
		? frac_add(k_frac, DL_M) : fexp_t'{sat: 1'b0, val: k_frac};
	assign fe = exp_total(fa.val, k_eneg, k_ed);

	always_comb begin
		fin = '0;
		if (k_ph == PH_PLUS || k_ph == PH_MINUS || k_ph == PH_NAN) begin
			fin.status = ST_NAN;
		end else begin
			fin.status = ST_NUM;
			fin.negative = k_sign;
			fin.mantissa = MANT_W'(k_acc);
			fin.dec_exponent = fe.val;
			fin.overflowed = k_sat | fa.sat | fe.sat;
		end
		fin.last = !line_end;
	end

	always_comb begin
		eol = '0;
		eol.status = ST_EOL;
		eol.last = 1'b1;
	end

	assign fin_emit = (k_ph != PH_IDLE) && (sep || line_end);
	assign res0 = fin_emit ? fin : eol;
	assign res1 = eol;
	assign nres = {1'b0, fin_emit} + {1'b0, line_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sign_q <= 1'b0;
			acc_q <= '0;
			frac_q <= '0;
			eneg_q <= 1'b0;
			ed_q <= '0;
			sat_q <= 1'b0;
		end else if (fire) begin
			if (sep || line_end) begin
				phase_q <= PH_IDLE;
				sign_q <= 1'b0;
				acc_q <= '0;
				frac_q <= '0;
				eneg_q <= 1'b0;
				ed_q <= '0;
				sat_q <= 1'b0;
			end else begin
				phase_q <= ph_f;
				sign_q <= sign_f;
				acc_q <= acc_f;
				frac_q <= fr_f.val;
				eneg_q <= eneg_f;
				ed_q <= ed_f;
				sat_q <= sat_f;
			end
		end
	end

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && line_end |=> phase_q == PH_IDLE && acc_q == '0)
		else $error("token state not cleared after line end");

	a_two_need_eol: assert property (@(posedge clk) disable iff (!arst_n)
		fire && nres == 2'd2 |-> line_end && res0.status != ST_EOL)
		else $error("two results without a line end");

	a_mant_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !sep && !line_end && acc_f == MANT_MAX && acc_q != MANT_MAX && do_mil
		|=> sat_q || acc_q == MANT_MAX)
		else $error("mantissa saturation lost");

endmodule

`default_nettype wire

@@ src/snp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module snp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    wr_cnt,
	input  snp_pkg::res_t      wr0,
	input  snp_pkg::res_t      wr1,
	output logic               room,
	output logic               rd_valid,
	input  wire logic          rd_stall,
	output snp_pkg::res_t      rd_data
);
	import snp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	res_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [PTR_W:0]     count_q;
	logic               rd;

	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);
	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign rd        = rd_valid && !rd_stall;
	assign room      = (count_q <= (PTR_W+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_cnt);
			rd_ptr_q <= rd_ptr_q + PTR_W'(rd);
			count_q <= count_q + (PTR_W+1)'(wr_cnt) - (PTR_W+1)'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_cnt != 2'd0 |-> count_q <= (PTR_W+1)'(DEPTH - 2))
		else $error("write into a full result queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(DEPTH))
		else $error("result queue count out of range");

endmodule

`default_nettype wire
